/* rtl/core/pfc_pkg.sv */
// pixel format converter package: transaction types, format codes, register indexes
// and the unorm8 <-> float32 conversion functions used by pixel_format_converter
// no dependencies
`default_nettype none

package pfc_pkg;

    localparam logic [2:0] FMT_R8      = 3'd0;
    localparam logic [2:0] FMT_RG8     = 3'd1;
    localparam logic [2:0] FMT_RGB8    = 3'd2;
    localparam logic [2:0] FMT_RGBA8   = 3'd3;
    localparam logic [2:0] FMT_RGBA32F = 3'd4;

    localparam logic [2:0] REG_SOURCE_FORMAT  = 3'd0;
    localparam logic [2:0] REG_DEST_FORMAT    = 3'd1;
    localparam logic [2:0] REG_EXTRACT_MODE   = 3'd2;
    localparam logic [2:0] REG_CHANNEL_SELECT = 3'd3;

    localparam logic [31:0] F32_ONE = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0] in_red;
        logic [31:0] in_green;
        logic [31:0] in_blue;
        logic [31:0] in_alpha;
        logic        end_of_image;
    } t_pixel_in;

    typedef struct packed {
        logic [31:0] out_red;
        logic [31:0] out_green;
        logic [31:0] out_blue;
        logic [31:0] out_alpha;
        logic        last_pixel;
    } t_pixel_out;

    // v/255 rounded to single: the binary expansion of v/255 is the byte v repeated,
    // so normalize the repeated pattern and round on the guard bit (never a tie)
    function automatic logic [31:0] unorm_to_f32(input logic [7:0] v);
        logic [2:0]  lz;
        logic        found;
        logic [39:0] pat;
        logic [23:0] man;
        logic [7:0]  ex;
        logic [31:0] res;
        lz    = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz    = 3'(7 - i);
                found = 1'b1;
            end
        end
        pat = {v, v, v, v, v} << lz;
        man = {1'b0, pat[38:16]} + {23'd0, pat[15]};
        ex  = 8'd126 - {5'd0, lz} + {7'd0, man[23]};
        if (v == 8'd0) begin
            res = 32'd0;
        end else if (v == 8'hFF) begin
            res = F32_ONE;
        end else begin
            res = {1'b0, ex, man[22:0]};
        end
        return res;
    endfunction

    // float bits times 255.0f (round to nearest even), truncated, saturated to 0..255
    function automatic logic [7:0] f32_to_unorm(input logic [31:0] b);
        logic [7:0]  ex;
        logic [23:0] m;
        logic [31:0] q;
        logic [23:0] kept;
        logic        g;
        logic        s;
        logic [24:0] qr;
        logic [32:0] rq;
        logic [4:0]  sh;
        logic [7:0]  res;
        ex = b[30:23];
        m  = {1'b1, b[22:0]};
        q  = {m, 8'd0} - {8'd0, m};
        if (q[31]) begin
            kept = q[31:8];
            g    = q[7];
            s    = |q[6:0];
        end else begin
            kept = q[30:7];
            g    = q[6];
            s    = |q[5:0];
        end
        qr = {1'b0, kept} + {24'd0, g & (s | kept[0])};
        if (q[31]) begin
            rq = {qr, 8'd0};
        end else begin
            rq = {1'b0, qr, 7'd0};
        end
        sh = 5'(8'd150 - ex);
        priority if (ex == 8'hFF && b[22:0] != 23'd0) begin
            res = 8'd0;
        end else if (b[31]) begin
            res = 8'd0;
        end else if (ex >= 8'd127) begin
            res = 8'hFF;
        end else if (ex < 8'd119) begin
            res = 8'd0;
        end else begin
            res = 8'(rq >> sh);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pixel_format_converter.sv */
// input register, then result register; the conversion is a single combinational pass
// between the two registers (byte normalize, 24x8 constant multiply and round per channel)
// throughput: one pixel per cycle while the output is not stalled
// reset: synchronous active-low i_rst_n clears the pipeline valids and loads the
// registers with source RGBA8, destination RGBA8, convert mode, red channel
`default_nettype none

module pixel_format_converter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  pfc_pkg::t_pixel_in   i_in_data,
    // output channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pfc_pkg::t_pixel_out  o_out_data,
    // configuration writes
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_index,
    input  wire [2:0]            i_cfg_data
);

    // configuration registers
    logic [2:0] r_source_format;
    logic [2:0] r_dest_format;
    logic       r_extract_mode;
    logic [1:0] r_channel_select;

    // pipeline
    logic                r_v1;
    pfc_pkg::t_pixel_in  r_s1;
    logic                r_v2;
    pfc_pkg::t_pixel_out r_s2;

    logic                adv1;
    logic                adv2;
    pfc_pkg::t_pixel_out n_s2;

    logic [31:0] c [4];
    logic [31:0] enc0_src;
    logic [7:0]  u [4];
    logic        src_unorm;
    logic        dst_unorm;

    // each stage moves when it is empty or the one after it is moving
    assign adv2       = !r_v2 || !i_out_stall;
    assign adv1       = !r_v1 || adv2;
    assign o_in_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format  <= pfc_pkg::FMT_RGBA8;
            r_dest_format    <= pfc_pkg::FMT_RGBA8;
            r_extract_mode   <= 1'b0;
            r_channel_select <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfc_pkg::REG_SOURCE_FORMAT:  r_source_format  <= i_cfg_data;
                pfc_pkg::REG_DEST_FORMAT:    r_dest_format    <= i_cfg_data;
                pfc_pkg::REG_EXTRACT_MODE:   r_extract_mode   <= i_cfg_data[0];
                pfc_pkg::REG_CHANNEL_SELECT: r_channel_select <= i_cfg_data[1:0];
                default: ;  // indexes past the register list are ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (adv2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    // decode to float32 channel bits; undefined source codes act as float
    always_comb begin
        src_unorm = (r_source_format == pfc_pkg::FMT_R8)   ||
                    (r_source_format == pfc_pkg::FMT_RG8)  ||
                    (r_source_format == pfc_pkg::FMT_RGB8) ||
                    (r_source_format == pfc_pkg::FMT_RGBA8);
        unique case (r_source_format)
            pfc_pkg::FMT_R8: begin
                c[0] = pfc_pkg::unorm_to_f32(r_s1.in_red[7:0]);
                c[1] = c[0];
                c[2] = c[0];
                c[3] = pfc_pkg::F32_ONE;
            end
            pfc_pkg::FMT_RG8: begin
                c[0] = pfc_pkg::unorm_to_f32(r_s1.in_red[7:0]);
                c[1] = pfc_pkg::unorm_to_f32(r_s1.in_green[7:0]);
                c[2] = 32'd0;
                c[3] = pfc_pkg::F32_ONE;
            end
            pfc_pkg::FMT_RGB8: begin
                c[0] = pfc_pkg::unorm_to_f32(r_s1.in_red[7:0]);
                c[1] = pfc_pkg::unorm_to_f32(r_s1.in_green[7:0]);
                c[2] = pfc_pkg::unorm_to_f32(r_s1.in_blue[7:0]);
                c[3] = pfc_pkg::F32_ONE;
            end
            pfc_pkg::FMT_RGBA8: begin
                c[0] = pfc_pkg::unorm_to_f32(r_s1.in_red[7:0]);
                c[1] = pfc_pkg::unorm_to_f32(r_s1.in_green[7:0]);
                c[2] = pfc_pkg::unorm_to_f32(r_s1.in_blue[7:0]);
                c[3] = pfc_pkg::unorm_to_f32(r_s1.in_alpha[7:0]);
            end
            default: begin
                c[0] = r_s1.in_red;
                c[1] = r_s1.in_green;
                c[2] = r_s1.in_blue;
                c[3] = r_s1.in_alpha;
            end
        endcase
    end

    // four unorm encoders; channel 0 takes the selected channel in extract mode
    always_comb begin
        enc0_src = r_extract_mode ? c[r_channel_select] : c[0];
        u[0] = pfc_pkg::f32_to_unorm(enc0_src);
        u[1] = pfc_pkg::f32_to_unorm(c[1]);
        u[2] = pfc_pkg::f32_to_unorm(c[2]);
        u[3] = pfc_pkg::f32_to_unorm(c[3]);
    end

    // encode to destination layout; absent channels are zero
    always_comb begin
        dst_unorm  = 1'b1;
        n_s2       = '0;
        n_s2.last_pixel = r_s1.end_of_image;
        if (r_extract_mode) begin
            n_s2.out_red = {24'd0, u[0]};
        end else begin
            unique case (r_dest_format)
                pfc_pkg::FMT_R8: begin
                    n_s2.out_red = {24'd0, u[0]};
                end
                pfc_pkg::FMT_RG8: begin
                    n_s2.out_red   = {24'd0, u[0]};
                    n_s2.out_green = {24'd0, u[1]};
                end
                pfc_pkg::FMT_RGB8: begin
                    n_s2.out_red   = {24'd0, u[0]};
                    n_s2.out_green = {24'd0, u[1]};
                    n_s2.out_blue  = {24'd0, u[2]};
                end
                pfc_pkg::FMT_RGBA8: begin
                    n_s2.out_red   = {24'd0, u[0]};
                    n_s2.out_green = {24'd0, u[1]};
                    n_s2.out_blue  = {24'd0, u[2]};
                    n_s2.out_alpha = {24'd0, u[3]};
                end
                default: begin
                    // float destination: bits copied exactly, nan payloads included
                    dst_unorm      = 1'b0;
                    n_s2.out_red   = c[0];
                    n_s2.out_green = c[1];
                    n_s2.out_blue  = c[2];
                    n_s2.out_alpha = c[3];
                end
            endcase
        end
    end

    assign o_out_valid = r_v2;
    assign o_out_data  = r_s2;

`ifndef NO_ASSERTIONS
    // the input side only stalls when both stages hold a pixel and the output is blocked
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && i_out_stall))
        else $error("input stalled while pipeline has room");

    // an accepted pixel always lands in the input register
    a_accept_loads_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted transaction lost at input register");

    // a unorm destination from a unorm source never produces a red result wider than 8 bits
    a_unorm_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2 && dst_unorm && src_unorm) |=> (r_s2.out_red[31:8] == 24'd0))
        else $error("unorm result exceeds one byte");
`endif

endmodule

`default_nettype wire
